### sv/ogg_page_packet_deframer_core_assert.svh
// assertion macros for the ogg page packet deframer checker
// no dependencies; included by oppd_checker.sv
`ifndef OGG_PAGE_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define OGG_PAGE_PACKET_DEFRAMER_CORE_ASSERT_SVH

// a stalled transaction keeps valid high and its payload steady
`define OPPD_ASSERT_HOLD(label, clk, rst_n, vld, rdy, data) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(data))) \
        else $error("stalled transaction changed");

// same-cycle implication
`define OPPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define OPPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### sv/oppd_pkg.sv
// shared types and constants for the ogg page packet deframer
// no dependencies; imported by every module of the block but oppd_ram
package oppd_pkg;

    localparam int LACE_DEPTH = 255;
    localparam int LACE_AW    = 8;
    localparam int LACE_DW    = 8;

    localparam logic [4:0] HDR_PATTERN_LEN = 5'd4;
    localparam logic [4:0] HDR_SEGS        = 5'd26;
    localparam logic [7:0] MAX_LACE        = 8'd255;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       body_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       packet_end;
        logic       framing_error;
    } t_out_item;

    typedef struct packed {
        logic step;
        logic skip_end;
        logic skip_read;
        logic skip_check;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic needs_skip;
        logic at_end;
        logic rd_zero;
        logic has_res;
        logic out_free;
    } t_status;

    // capture pattern "OggS"
    function automatic logic [7:0] f_capture(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h4F;
            2'd1:    v = 8'h67;
            2'd2:    v = 8'h67;
            default: v = 8'h53;
        endcase
        return v;
    endfunction

endpackage

### sv/oppd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module oppd_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 255
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/oppd_ctrl.sv
// controller state machine of the ogg page packet deframer
// depends on oppd_pkg (command and status types)
module oppd_ctrl
    import oppd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SKIP = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.step = 1'b1;
                    n_state    = i_status.needs_skip ? S_SKIP : S_DONE;
                end
            end
            S_SKIP: begin
                if (i_status.at_end) begin
                    o_cmd.skip_end = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.skip_read = 1'b1;
                    n_state         = S_WAIT;
                end
            end
            S_WAIT: begin
                o_cmd.skip_check = 1'b1;
                n_state          = i_status.rd_zero ? S_SKIP : S_DONE;
            end
            S_DONE: begin
                if (!i_status.has_res || i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/oppd_datapath.sv
// datapath of the ogg page packet deframer: parser registers and output register
// depends on oppd_pkg; drives the lace table ram ports
module oppd_datapath
    import oppd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    output logic               o_ram_we,
    output logic [LACE_AW-1:0] o_ram_waddr,
    output logic [LACE_DW-1:0] o_ram_wdata,
    output logic               o_ram_re,
    output logic [LACE_AW-1:0] o_ram_raddr,
    input  logic [LACE_DW-1:0] i_ram_rdata
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LACING = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_HALT   = 2'd3;

    logic [1:0]  r_phase,     n_phase;
    logic [4:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [7:0]  r_seg_cnt,   n_seg_cnt;
    logic [7:0]  r_seg_idx,   n_seg_idx;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_cur_lace,  n_cur_lace;
    logic        r_open,      n_open;
    logic        r_last,      n_last;
    logic        r_has_res,   n_has_res;
    t_out_item   r_res,       n_res;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out,       n_out;

    logic [7:0] w_byte;
    logic [8:0] w_idx_inc;
    logic [7:0] w_bl_dec;

    assign w_byte    = i_in_item.in_byte;
    assign w_idx_inc = {1'b0, r_seg_idx} + 9'd1;
    assign w_bl_dec  = r_bytes_left - {7'd0, (r_bytes_left != 8'd0)};

    always_comb begin
        o_status.needs_skip = ((r_phase == PH_LACING) && (w_idx_inc >= {1'b0, r_seg_cnt}))
                           || ((r_phase == PH_DATA) && (r_bytes_left <= 8'd1));
        o_status.at_end     = (r_seg_idx >= r_seg_cnt);
        o_status.rd_zero    = (i_ram_rdata == 8'd0);
        o_status.has_res    = r_has_res;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_ram_waddr = r_seg_idx;
    assign o_ram_wdata = w_byte;
    assign o_ram_raddr = r_seg_idx;
    assign o_ram_re    = i_cmd.skip_read;

    always_comb begin
        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_seg_cnt    = r_seg_cnt;
        n_seg_idx    = r_seg_idx;
        n_bytes_left = r_bytes_left;
        n_cur_lace   = r_cur_lace;
        n_open       = r_open;
        n_last       = r_last;
        n_has_res    = r_has_res;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_ram_we     = 1'b0;

        if (i_cmd.step) begin
            n_last    = i_in_item.body_last;
            n_has_res = 1'b0;
            n_res     = '0;
            unique case (r_phase)
                PH_HEADER: begin
                    if ((r_hdr_cnt < HDR_PATTERN_LEN) && (w_byte != f_capture(r_hdr_cnt[1:0])))
                    begin
                        n_res.framing_error = 1'b1;
                        n_has_res           = 1'b1;
                        n_phase             = PH_HALT;
                    end else if (r_hdr_cnt >= HDR_SEGS) begin
                        n_seg_cnt = w_byte;
                        n_seg_idx = 8'd0;
                        n_hdr_cnt = 5'd0;
                        if (w_byte != 8'd0) begin
                            n_phase = PH_LACING;
                        end
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 5'd1;
                    end
                end
                PH_LACING: begin
                    o_ram_we = 1'b1;
                    if (w_idx_inc >= {1'b0, r_seg_cnt}) begin
                        n_seg_idx = 8'd0;
                    end else begin
                        n_seg_idx = w_idx_inc[7:0];
                    end
                end
                PH_DATA: begin
                    n_res.out_byte     = w_byte;
                    n_res.byte_present = 1'b1;
                    n_has_res          = 1'b1;
                    n_open             = 1'b1;
                    n_bytes_left       = w_bl_dec;
                    if (w_bl_dec == 8'd0) begin
                        n_seg_idx = w_idx_inc[7:0];
                        if (r_cur_lace < MAX_LACE) begin
                            n_res.packet_end = 1'b1;
                            n_open           = 1'b0;
                        end
                    end
                end
                PH_HALT: begin
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.skip_end) begin
            n_phase      = PH_HEADER;
            n_hdr_cnt    = 5'd0;
            n_bytes_left = 8'd0;
        end

        if (i_cmd.skip_check) begin
            if (i_ram_rdata == 8'd0) begin
                if (r_open) begin
                    n_open           = 1'b0;
                    n_res.packet_end = 1'b1;
                    n_has_res        = 1'b1;
                end
                n_seg_idx = w_idx_inc[7:0];
            end else begin
                n_bytes_left = i_ram_rdata;
                n_cur_lace   = i_ram_rdata;
                n_phase      = PH_DATA;
            end
        end

        if (i_cmd.finish) begin
            if (r_has_res) begin
                n_out_valid = 1'b1;
                n_out       = r_res;
                n_has_res   = 1'b0;
            end
            // end of body puts the parser back to its reset state
            if (r_last) begin
                n_phase      = PH_HEADER;
                n_hdr_cnt    = 5'd0;
                n_seg_cnt    = 8'd0;
                n_seg_idx    = 8'd0;
                n_bytes_left = 8'd0;
                n_open       = 1'b0;
                n_last       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_cnt    <= 5'd0;
            r_seg_cnt    <= 8'd0;
            r_seg_idx    <= 8'd0;
            r_bytes_left <= 8'd0;
            r_open       <= 1'b0;
            r_last       <= 1'b0;
            r_has_res    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_seg_cnt    <= n_seg_cnt;
            r_seg_idx    <= n_seg_idx;
            r_bytes_left <= n_bytes_left;
            r_open       <= n_open;
            r_last       <= n_last;
            r_has_res    <= n_has_res;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_lace <= n_cur_lace;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### sv/ogg_page_packet_deframer_core.sv
// top level of the ogg page packet deframer
// depends on oppd_pkg, oppd_ctrl, oppd_datapath and oppd_ram
//
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_item) takes one body byte per
//   transaction, with body_last set on the final byte of the ogg body
//   output channel (o_out_valid / i_out_ready / o_out_item) gives at most one
//   result per input byte: a payload byte, a marker-only packet end, or a
//   single framing error after a capture pattern mismatch
// timing:
//   header, lacing and mid-segment data bytes pass the accept and finish states
//   a byte that ends a segment or the lacing table also passes the skip state,
//   and, unless no segment is left on the page, the wait state; every zero lace
//   skipped adds another skip and wait (one lace table ram read each)
//   a result is visible the cycle after its byte is finished
// stalls:
//   the output register holds one finished result; the next byte is accepted
//   while it waits, and that byte's result waits in the datapath until the
//   output register frees, with o_in_ready low meanwhile
// reset:
//   i_rst_n is synchronous, active low; the parser returns to the header phase
//   and no transaction is taken while it is low; the lace table is not cleared
//   (only entries written on the current page are read)
module ogg_page_packet_deframer_core
    import oppd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd    w_cmd;
    t_status w_status;

    // lace table ram ports
    logic               w_ram_we;
    logic [LACE_AW-1:0] w_ram_waddr;
    logic [LACE_DW-1:0] w_ram_wdata;
    logic               w_ram_re;
    logic [LACE_AW-1:0] w_ram_raddr;
    logic [LACE_DW-1:0] w_ram_rdata;

    // sequencer: step, zero-lace skip loop, result hand-off
    oppd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // parser registers, pending result and output register
    oppd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    // one lace per segment of the current page
    oppd_ram #(
        .P_WIDTH (LACE_DW),
        .P_DEPTH (LACE_DEPTH)
    ) u_lace_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

### sv/oppd_checker.sv
// port-level assertions for the ogg page packet deframer, bound to the top level
// depends on oppd_pkg and ogg_page_packet_deframer_core_assert.svh
`include "ogg_page_packet_deframer_core_assert.svh"

module oppd_checker
    import oppd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    `OPPD_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_ready, o_out_item)

    `OPPD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_item.body_last || !i_in_item.body_last), !o_in_ready)

    `OPPD_ASSERT_IMPL(a_err_alone, i_clk, i_rst_n, o_out_valid && o_out_item.framing_error, !o_out_item.byte_present && !o_out_item.packet_end)

    `OPPD_ASSERT_IMPL(a_marker_ends, i_clk, i_rst_n, o_out_valid && !o_out_item.byte_present && !o_out_item.framing_error, o_out_item.packet_end)

    `OPPD_ASSERT_IMPL(a_empty_byte_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.byte_present, o_out_item.out_byte == 8'd0)

endmodule

bind ogg_page_packet_deframer_core oppd_checker u_oppd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

### test/oppd_checker.sv
// result checker for the ogg page packet deframer: follows the parser from
// accepted input transactions and compares each output transaction in order
// depends on oppd_pkg
module oppd_scoreboard
    import oppd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_payload_count,
    output int        o_end_count,
    output int        o_marker_count,
    output int        o_error_count
);

    localparam logic [31:0] CAPTURE_WORD = 32'h4F67_6753;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_LACING,
        ST_DATA,
        ST_HALTED
    } t_parse_state;

    t_parse_state parse_state;
    logic [4:0]   hdr_pos;
    logic [7:0]   seg_total;
    logic [7:0]   seg_pos;
    logic [7:0]   seg_left;
    logic         pkt_open;
    logic [7:0]   lace_mem [LACE_DEPTH];
    t_out_item    pending_results [$];

    function automatic void reset_parser();
        parse_state = ST_HEADER;
        hdr_pos     = '0;
        seg_total   = '0;
        seg_pos     = '0;
        seg_left    = '0;
        pkt_open    = 1'b0;
    endfunction

    function automatic logic [7:0] lace_of(input logic [7:0] idx);
        return (idx < LACE_DEPTH) ? lace_mem[idx] : 8'd0;
    endfunction

    // step over zero laces; true when one of them closed an open packet
    function automatic logic skip_zero_laces();
        logic closed;
        closed = 1'b0;
        while (seg_pos < seg_total && lace_of(seg_pos) == 8'd0) begin
            if (pkt_open) begin
                pkt_open = 1'b0;
                closed   = 1'b1;
            end
            seg_pos++;
        end
        if (seg_pos < seg_total) begin
            seg_left    = lace_of(seg_pos);
            parse_state = ST_DATA;
        end else begin
            parse_state = ST_HEADER;
            hdr_pos     = '0;
            seg_left    = '0;
        end
        return closed;
    endfunction

    // advance the parser by one body byte; true when a result is due
    function automatic logic deframe_byte(input t_in_item it, output t_out_item res);
        logic       hit;
        logic [7:0] lace;
        hit = 1'b0;
        res = '0;
        case (parse_state)
            ST_HEADER: begin
                if (hdr_pos < HDR_PATTERN_LEN &&
                    it.in_byte != CAPTURE_WORD[31 - 8 * hdr_pos[1:0] -: 8]) begin
                    res.framing_error = 1'b1;
                    hit               = 1'b1;
                    parse_state       = ST_HALTED;
                end else if (hdr_pos >= HDR_SEGS) begin
                    seg_total = it.in_byte;
                    seg_pos   = '0;
                    hdr_pos   = '0;
                    if (it.in_byte != 8'd0) begin
                        parse_state = ST_LACING;
                    end
                end else begin
                    hdr_pos++;
                end
            end
            ST_LACING: begin
                if (seg_pos < LACE_DEPTH) begin
                    lace_mem[seg_pos] = it.in_byte;
                end
                seg_pos++;
                if (seg_pos >= seg_total) begin
                    seg_pos = '0;
                    if (skip_zero_laces()) begin
                        res.packet_end = 1'b1;
                        hit            = 1'b1;
                    end
                end
            end
            ST_DATA: begin
                res.out_byte     = it.in_byte;
                res.byte_present = 1'b1;
                hit              = 1'b1;
                pkt_open         = 1'b1;
                if (seg_left > 8'd0) begin
                    seg_left--;
                end
                if (seg_left == 8'd0) begin
                    lace = lace_of(seg_pos);
                    seg_pos++;
                    if (lace < MAX_LACE) begin
                        res.packet_end = 1'b1;
                        pkt_open       = 1'b0;
                    end
                    if (skip_zero_laces()) begin
                        res.packet_end = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (it.body_last) begin
            reset_parser();
        end
        return hit;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item predicted;
        t_out_item oldest;
        if (!i_rst_n) begin
            reset_parser();
            pending_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (deframe_byte(i_in_item, predicted)) begin
                    pending_results = {pending_results, predicted};
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (i_out_item.byte_present) o_payload_count++;
                if (i_out_item.packet_end) o_end_count++;
                if (i_out_item.packet_end && !i_out_item.byte_present) o_marker_count++;
                if (i_out_item.framing_error) o_error_count++;
                if (pending_results.size() == 0) begin
                    $error("output transaction with no result due: byte %0d present %0b end %0b err %0b",
                           i_out_item.out_byte, i_out_item.byte_present,
                           i_out_item.packet_end, i_out_item.framing_error);
                    o_fail_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("out_byte", oldest.out_byte, i_out_item.out_byte);
                    check_field("byte_present", oldest.byte_present, i_out_item.byte_present);
                    check_field("packet_end", oldest.packet_end, i_out_item.packet_end);
                    check_field("framing_error", oldest.framing_error,
                                i_out_item.framing_error);
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

### test/testbench.sv
// testbench top for the ogg page packet deframer: builds ogg bodies, drives the
// input channel, paces the output channel and gives the verdict
// depends on oppd_pkg, ogg_page_packet_deframer_core and oppd_scoreboard
module testbench;
    import oppd_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          N_ITEMS      = 1750;     // random-run bytes the parser looks at
    localparam int          HOLD_CYCLES  = 200;      // long receiver hold-off
    localparam int          DRAIN_CYCLES = 600;      // covers a full table of zero laces
    localparam int          WAIT_CYCLES  = 50_000;   // bound on the final drain
    localparam int          LIMIT_CYCLES = 500_000;
    localparam logic [31:0] CAPTURE_WORD = 32'h4F67_6753;

    // idling regimes of the two channels
    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SINK_STALL,
        PACE_BOTH
    } t_pace;

    // flavors of body built around a full 255-byte segment
    typedef enum logic [1:0] {
        LONG_FOLD,      // zero lace right after the full segment, same page
        LONG_MARKER,    // full segment ends the page, next page opens with a zero lace
        LONG_SPAN       // packet runs on into the next page
    } t_long;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    int fail_total;
    int pending_total;
    int payload_total;
    int end_total;
    int marker_total;
    int error_total;

    // stimulus state
    logic [7:0] body_q [$];     // bytes of the body being built
    int         page_at [$];    // offset of each page header in body_q
    logic [7:0] lace_q [$];     // lacing table of the page being built
    int         items_done  = 0;
    int         body_count  = 0;
    int         long_count  = 0;
    int         src_idle_pct  = 0;
    int         rcv_stall_pct = 0;
    bit         hold_req      = 1'b0;

    ogg_page_packet_deframer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    oppd_scoreboard u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_item       (i_in_item),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_item      (o_out_item),
        .o_fail_count    (fail_total),
        .o_pending       (pending_total),
        .o_payload_count (payload_total),
        .o_end_count     (end_total),
        .o_marker_count  (marker_total),
        .o_error_count   (error_total)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // hard stop in case the handshakes hang
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("testbench failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request so the
    // block fills up and has to drop o_in_ready
    initial begin : receiver
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic set_pace(input t_pace pace);
        src_idle_pct  = (pace == PACE_SRC_IDLE)   ? 87 : (pace == PACE_BOTH) ? 20 : 0;
        rcv_stall_pct = (pace == PACE_SINK_STALL) ? 87 : (pace == PACE_BOTH) ? 20 : 0;
    endtask

    // one input transaction; called and left at a falling edge, valid stays
    // high between back-to-back bytes
    task automatic send_item(input logic [7:0] b, input logic last);
        t_in_item nxt;
        nxt.in_byte   = b;
        nxt.body_last = last;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= nxt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // send the built body with body_last on its final byte; counted is the
    // number of bytes the parser actually looks at
    task automatic send_body(input int counted);
        for (int k = 0; k < body_q.size(); k++) begin
            send_item(body_q[k], k == body_q.size() - 1);
        end
        items_done += counted;
        body_count++;
        body_q.delete();
        page_at.delete();
    endtask

    // page = capture pattern, 22 don't-care header bytes, segment count,
    // lacing table, then random data bytes for every segment
    task automatic add_page();
        page_at = {page_at, body_q.size()};
        for (int k = 0; k < 4; k++) body_q = {body_q, CAPTURE_WORD[31 - 8 * k -: 8]};
        for (int k = 4; k < HDR_SEGS; k++) body_q = {body_q, 8'($urandom_range(255))};
        body_q = {body_q, 8'(lace_q.size())};
        foreach (lace_q[s]) body_q = {body_q, lace_q[s]};
        foreach (lace_q[s]) begin
            for (int d = 0; d < lace_q[s]; d++) body_q = {body_q, 8'($urandom_range(255))};
        end
        lace_q.delete();
    endtask

    // mostly short segments, some zero laces, rarely a full one
    function automatic logic [7:0] pick_lace();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 8'd0;
        if (r < 17) return MAX_LACE;
        if (r < 22) return 8'($urandom_range(40, 13));
        return 8'($urandom_range(12, 1));
    endfunction

    task automatic add_picks(input int n);
        repeat (n) lace_q = {lace_q, pick_lace()};
    endtask

    task automatic build_long_body();
        t_long kind;
        kind = t_long'(long_count % 3);
        long_count++;
        add_picks($urandom_range(2));
        lace_q = {lace_q, MAX_LACE};
        if (kind == LONG_FOLD) begin
            // end mark folds into the last byte of the full segment
            lace_q = {lace_q, 8'd0};
            add_picks($urandom_range(2));
            add_page();
        end else begin
            add_page();
            // for LONG_MARKER a zero lace up front gives the marker-only result
            lace_q = {lace_q, ((kind == LONG_MARKER) ? 8'd0 : 8'($urandom_range(12, 1)))};
            add_picks($urandom_range(2));
            add_page();
        end
    endtask

    task automatic build_plain_body();
        repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(99) >= 8) begin
                add_picks($urandom_range(6, 1));
            end
            add_page();    // no picks: empty page
        end
    endtask

    // break some plain bodies: a bad capture byte on a random page (up to three
    // ignored bytes follow it), or a cut at a random point
    task automatic break_body(output int counted);
        int r;
        int cut;
        int hit_at;
        r       = $urandom_range(99);
        cut     = body_q.size();
        counted = body_q.size();
        if (r < 8) begin
            hit_at         = page_at[$urandom_range(page_at.size() - 1)] + $urandom_range(3);
            body_q[hit_at] = body_q[hit_at] ^ 8'($urandom_range(255, 1));
            counted        = hit_at + 1;
            cut            = hit_at + 1 + $urandom_range(3);
        end else if (r < 20) begin
            cut     = $urandom_range(body_q.size(), 1);
            counted = cut;
        end
        while (body_q.size() > cut) void'(body_q.pop_back());
    endtask

    initial begin : stimulus
        int rand_base;
        int counted;
        int guard;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        set_pace(PACE_FREE);
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: capture mismatch at each pattern position, bad byte
        // alternating all-zeros and all-ones; a trailing byte while halted
        for (int pos = 0; pos < 4; pos++) begin
            for (int k = 0; k < pos; k++) body_q = {body_q, CAPTURE_WORD[31 - 8 * k -: 8]};
            body_q = {body_q, ((pos % 2 == 1) ? 8'hFF : 8'h00)};
            if (pos == 3) begin
                body_q = {body_q, CAPTURE_WORD[7:0]};
            end
            send_body(pos + 1);
        end

        // directed: empty page, then zero laces with no packet open around
        // short segments; data bytes at the extremes
        add_page();
        lace_q = {lace_q, 8'd0};
        lace_q = {lace_q, 8'd1};
        lace_q = {lace_q, 8'd0};
        lace_q = {lace_q, 8'd2};
        add_page();
        body_q[body_q.size() - 3] = 8'h00;
        body_q[body_q.size() - 2] = 8'hFF;
        body_q[body_q.size() - 1] = 8'h80;
        send_body(body_q.size());

        // random bodies; the idling regime moves on every quarter of the run
        rand_base = items_done;
        hold_req  = 1'b1;
        while (items_done - rand_base < N_ITEMS) begin
            set_pace(t_pace'(((items_done - rand_base) * 4) / N_ITEMS));
            if ($urandom_range(99) < 5) begin
                // noise body: random bytes, almost always a capture mismatch
                repeat ($urandom_range(6, 1)) body_q = {body_q, 8'($urandom_range(255))};
                send_body(1);
            end else if (body_count % 3 == 1) begin
                build_long_body();
                send_body(body_q.size());
            end else if (body_count == 8) begin
                // full lacing table, mostly zero laces
                repeat (LACE_DEPTH) begin
                    lace_q = {lace_q, (($urandom_range(15) == 0) ?
                                       8'($urandom_range(4, 1)) : 8'd0)};
                end
                add_page();
                send_body(body_q.size());
            end else begin
                build_plain_body();
                break_body(counted);
                send_body(counted);
            end
        end
        i_in_valid <= 1'b0;

        // drain: wait for every due result, then let a late stray show up
        set_pace(PACE_FREE);
        guard = 0;
        while (pending_total != 0 && guard < WAIT_CYCLES) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_total != 0) begin
            $error("%0d predicted results never arrived", pending_total);
        end

        $display("covered %0d input transactions in %0d ogg bodies, %0d with a full segment",
                 items_done, body_count, long_count);
        $display("results seen: %0d payload bytes, %0d packet ends (%0d marker-only), %0d framing errors",
                 payload_total, end_total, marker_total, error_total);
        if (fail_total == 0 && pending_total == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
